// ----- rtl/tbbl_pkg.sv -----
`default_nettype none

package tbbl_pkg;

    // field widths
    localparam int BYTE_W      = 32;
    localparam int TIME_W      = 64;
    localparam int RATE_W      = 24;
    localparam int KB_W        = 20;
    localparam int AVAIL_W     = 21;
    localparam int TOTAL_W     = 64;

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE     = 2'd0,
        REG_CAPACITY = 2'd1,
        REG_BURST    = 2'd2
    } cfg_reg_t;

    // register values after reset
    localparam logic [RATE_W-1:0] RESET_RATE_KB     = 24'd0;
    localparam logic [KB_W-1:0]   RESET_CAPACITY_KB = 20'd1024;
    localparam logic [KB_W-1:0]   RESET_BURST_KB    = 20'd0;

    // token unit is 1/1024000 KB: one byte is 1000 units, one ms at rate r is r*1024
    localparam int BYTE_UNITS   = 1000;
    localparam int KB_UNITS     = 1024000;
    localparam int UNIT_SHIFT   = 10;

    // elapsed time at or above 2^31 ms always fills any ceiling
    localparam int ELAPSED_W    = 31;
    localparam int PROD_W       = ELAPSED_W + RATE_W;
    localparam int REFILL_W     = PROD_W + UNIT_SHIFT;
    localparam int NEED_W       = BYTE_W + UNIT_SHIFT;
    localparam int CALC_W       = REFILL_W + 1;

    // the level never exceeds the largest ceiling, which is below 2^41
    localparam int LVL_W        = 41;

    // floor(level / 1024000) = floor((level >> 13) / 125), by reciprocal
    localparam int KB_SHIFT     = 13;
    localparam int QUOT_X_W     = LVL_W - KB_SHIFT;
    localparam int RECIP_W      = 29;
    localparam logic [RECIP_W-1:0] RECIP_125 = 29'd274877907;
    localparam int RECIP_SHIFT  = 35;
    localparam int QPROD_W      = QUOT_X_W + RECIP_W;

    typedef enum logic [1:0] {
        REFILL_NONE,
        REFILL_ADD,
        REFILL_FULL
    } refill_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    bytes;
        logic                 bypass;
        refill_kind_t         kind;
        logic [ELAPSED_W-1:0] elapsed;
    } s1_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    bytes;
        logic                 bypass;
        refill_kind_t         kind;
        logic [REFILL_W-1:0]  refill_units;
        logic [NEED_W-1:0]    need;
    } s2_item_t;

    typedef struct packed {
        logic                 granted;
        logic [LVL_W-1:0]     level;
        logic [TOTAL_W-1:0]   allowed_sum;
        logic [TOTAL_W-1:0]   rejected_sum;
    } s3_item_t;

endpackage

`default_nettype wire

// ----- rtl/token_bucket_byte_limiter_top.sv -----
`default_nettype none

// token bucket byte limiter
//
// input channel (in_valid / in_ready) carries one transfer request item:
// byte_count bytes at time now_ms in milliseconds. output channel
// (out_valid / out_ready) returns one result item per request: granted,
// the whole KB left in the bucket, and the running granted and rejected
// byte totals, which wrap at 64 bits.
// configuration: cfg_write with cfg_index 0 = rate in KB/s (0 turns
// limiting off), 1 = bucket capacity in KB, 2 = burst allowance in KB;
// other indexes are dropped. write only while no item is in flight.
// an accepted item passes the stage 1 to stage 4 registers in order before
// out_valid; one item per cycle is sustained while out_ready stays high.
// the four pipeline registers hold up to four items, so input keeps
// flowing while a result waits on out_ready; once all are full, in_ready
// drops in the same cycle as out_ready.
// reset: bucket full at 1024 KB, time unset, totals zero, rate 0,
// capacity 1024 KB, burst 0.

module token_bucket_byte_limiter_top #(
    parameter int TOKEN_WIDTH = 42
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [tbbl_pkg::BYTE_W-1:0]     byte_count,
    input  wire logic [tbbl_pkg::TIME_W-1:0]     now_ms,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 granted,
    output logic [tbbl_pkg::AVAIL_W-1:0]         available_kb,
    output logic [tbbl_pkg::TOTAL_W-1:0]         allowed_bytes_total,
    output logic [tbbl_pkg::TOTAL_W-1:0]         rejected_bytes_total,
    input  wire logic                            cfg_write,
    input  wire logic [tbbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tbbl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tbbl_pkg::*;

    logic [RATE_W-1:0] rate_reg;
    logic [KB_W-1:0]   capacity_reg;
    logic [KB_W-1:0]   burst_reg;

    logic              s1_valid;
    logic              s1_ready;
    s1_item_t          s1_item;
    logic              s2_valid;
    logic              s2_ready;
    s2_item_t          s2_item;
    logic              s3_valid;
    logic              s3_ready;
    s3_item_t          s3_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg     <= RESET_RATE_KB;
            capacity_reg <= RESET_CAPACITY_KB;
            burst_reg    <= RESET_BURST_KB;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RATE:     rate_reg     <= cfg_data[RATE_W-1:0];
                REG_CAPACITY: capacity_reg <= cfg_data[KB_W-1:0];
                REG_BURST:    burst_reg    <= cfg_data[KB_W-1:0];
                default:      ;
            endcase
        end
    end

    // stage 1: timestamp tracking, elapsed time
    tbbl_time_track u_time (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .byte_count      (byte_count),
        .now_ms          (now_ms),
        .rate_kb_per_sec (rate_reg),
        .s1_valid        (s1_valid),
        .s1_ready        (s1_ready),
        .s1_item         (s1_item)
    );

    // stage 2: refill amount and request size in token units
    tbbl_refill_mul u_mul (
        .clk             (clk),
        .rst_n           (rst_n),
        .s1_valid        (s1_valid),
        .s1_ready        (s1_ready),
        .s1_item         (s1_item),
        .rate_kb_per_sec (rate_reg),
        .s2_valid        (s2_valid),
        .s2_ready        (s2_ready),
        .s2_item         (s2_item)
    );

    // stage 3: bucket level, grant decision, byte totals
    tbbl_token_update #(
        .TOKEN_WIDTH (TOKEN_WIDTH)
    ) u_bucket (
        .clk                (clk),
        .rst_n              (rst_n),
        .s2_valid           (s2_valid),
        .s2_ready           (s2_ready),
        .s2_item            (s2_item),
        .bucket_capacity_kb (capacity_reg),
        .burst_allowance_kb (burst_reg),
        .s3_valid           (s3_valid),
        .s3_ready           (s3_ready),
        .s3_item            (s3_item)
    );

    // stage 4: level to whole KB, output register
    tbbl_kb_div u_div (
        .clk                  (clk),
        .rst_n                (rst_n),
        .s3_valid             (s3_valid),
        .s3_ready             (s3_ready),
        .s3_item              (s3_item),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .granted              (granted),
        .available_kb         (available_kb),
        .allowed_bytes_total  (allowed_bytes_total),
        .rejected_bytes_total (rejected_bytes_total)
    );

endmodule

`default_nettype wire

// ----- rtl/tbbl_time_track.sv -----
`default_nettype none

module tbbl_time_track (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [tbbl_pkg::BYTE_W-1:0]  byte_count,
    input  wire logic [tbbl_pkg::TIME_W-1:0]  now_ms,
    input  wire logic [tbbl_pkg::RATE_W-1:0]  rate_kb_per_sec,
    output logic                              s1_valid,
    input  wire logic                         s1_ready,
    output tbbl_pkg::s1_item_t                s1_item
);
    import tbbl_pkg::*;

    logic                accept;
    logic [TIME_W-1:0]   last_time_reg;
    logic [TIME_W-1:0]   last_time_next;
    logic [TIME_W-1:0]   diff;
    logic                s1_valid_reg;
    s1_item_t            s1_item_reg;
    s1_item_t            s1_item_next;

    assign in_ready = !s1_valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;
    assign diff     = now_ms - last_time_reg;

    always_comb
    begin
        last_time_next       = last_time_reg;
        s1_item_next.bytes   = byte_count;
        s1_item_next.bypass  = 1'b0;
        s1_item_next.kind    = REFILL_NONE;
        s1_item_next.elapsed = diff[ELAPSED_W-1:0];
        if (rate_kb_per_sec == '0)
        begin
            s1_item_next.bypass = 1'b1;
        end
        else if (last_time_reg == '0)
        begin
            // first timestamp only records the time
            last_time_next = now_ms;
        end
        else if (now_ms > last_time_reg)
        begin
            last_time_next = now_ms;
            if (diff[TIME_W-1:ELAPSED_W] != '0)
                s1_item_next.kind = REFILL_FULL;
            else
                s1_item_next.kind = REFILL_ADD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            last_time_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg  <= 1'b1;
                last_time_reg <= last_time_next;
            end
            else if (s1_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= s1_item_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;

`ifndef SYNTHESIS
    // unlimited mode never touches the stored time
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rate_kb_per_sec == '0) |=> $stable(last_time_reg))
        else $error("stored time changed while limiting was off");
`endif

endmodule

`default_nettype wire

// ----- rtl/tbbl_refill_mul.sv -----
`default_nettype none

module tbbl_refill_mul (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s1_valid,
    output logic                              s1_ready,
    input  wire tbbl_pkg::s1_item_t           s1_item,
    input  wire logic [tbbl_pkg::RATE_W-1:0]  rate_kb_per_sec,
    output logic                              s2_valid,
    input  wire logic                         s2_ready,
    output tbbl_pkg::s2_item_t                s2_item
);
    import tbbl_pkg::*;

    logic              move;
    logic [PROD_W-1:0] prod;
    logic              s2_valid_reg;
    s2_item_t          s2_item_reg;
    s2_item_t          s2_item_next;

    assign s1_ready = !s2_valid_reg || s2_ready;
    assign move     = s1_valid && s1_ready;

    // elapsed ms times rate, then times 1024 as a shift
    assign prod = PROD_W'(s1_item.elapsed) * PROD_W'(rate_kb_per_sec);

    always_comb
    begin
        s2_item_next.bytes        = s1_item.bytes;
        s2_item_next.bypass       = s1_item.bypass;
        s2_item_next.kind         = s1_item.kind;
        s2_item_next.refill_units = {prod, {UNIT_SHIFT{1'b0}}};
        s2_item_next.need         = NEED_W'(s1_item.bytes) * NEED_W'(BYTE_UNITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (move)
            s2_valid_reg <= 1'b1;
        else if (s2_ready)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (move)
            s2_item_reg <= s2_item_next;
    end

    assign s2_valid = s2_valid_reg;
    assign s2_item  = s2_item_reg;

endmodule

`default_nettype wire

// ----- rtl/tbbl_token_update.sv -----
`default_nettype none

module tbbl_token_update #(
    parameter int TOKEN_WIDTH = 42
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s2_valid,
    output logic                            s2_ready,
    input  wire tbbl_pkg::s2_item_t         s2_item,
    input  wire logic [tbbl_pkg::KB_W-1:0]  bucket_capacity_kb,
    input  wire logic [tbbl_pkg::KB_W-1:0]  burst_allowance_kb,
    output logic                            s3_valid,
    input  wire logic                       s3_ready,
    output tbbl_pkg::s3_item_t              s3_item
);
    import tbbl_pkg::*;

    localparam logic [CALC_W-1:0] TOKEN_MAX =
        (CALC_W'(1) << TOKEN_WIDTH) - CALC_W'(1);
    localparam logic [CALC_W-1:0] RESET_RAW =
        CALC_W'(RESET_CAPACITY_KB) * CALC_W'(KB_UNITS);
    localparam logic [CALC_W-1:0] RESET_SAT =
        (RESET_RAW > TOKEN_MAX) ? TOKEN_MAX : RESET_RAW;
    localparam logic [CALC_W-1:0] RESET_CEIL_RAW =
        (CALC_W'(RESET_CAPACITY_KB) + CALC_W'(RESET_BURST_KB)) * CALC_W'(KB_UNITS);
    localparam logic [CALC_W-1:0] RESET_CEIL =
        (RESET_CEIL_RAW > TOKEN_MAX) ? TOKEN_MAX : RESET_CEIL_RAW;

    logic                    move;
    logic [CALC_W-1:0]       ceil_calc;
    logic [TOKEN_WIDTH-1:0]  ceiling_reg;
    logic [TOKEN_WIDTH-1:0]  ceiling_next;
    logic [TOKEN_WIDTH-1:0]  level_reg;
    logic [TOKEN_WIDTH-1:0]  level_next;
    logic [TOTAL_W-1:0]      allowed_sum_reg;
    logic [TOTAL_W-1:0]      allowed_sum_next;
    logic [TOTAL_W-1:0]      rejected_sum_reg;
    logic [TOTAL_W-1:0]      rejected_sum_next;
    logic [CALC_W-1:0]       lvl_ext;
    logic [CALC_W-1:0]       ceil_ext;
    logic [CALC_W-1:0]       need_ext;
    logic [CALC_W-1:0]       sum;
    logic [CALC_W-1:0]       refilled;
    logic [CALC_W-1:0]       left;
    logic                    ok;
    logic                    s3_valid_reg;
    s3_item_t                s3_item_reg;
    s3_item_t                s3_item_next;

    assign s2_ready = !s3_valid_reg || s3_ready;
    assign move     = s2_valid && s2_ready;

    // ceiling kept in a register, follows the configuration registers in the next cycle
    assign ceil_calc = (CALC_W'(bucket_capacity_kb) + CALC_W'(burst_allowance_kb))
                       * CALC_W'(KB_UNITS);
    assign ceiling_next = (ceil_calc > TOKEN_MAX) ? TOKEN_MAX[TOKEN_WIDTH-1:0]
                                                  : ceil_calc[TOKEN_WIDTH-1:0];

    assign lvl_ext  = CALC_W'(level_reg);
    assign ceil_ext = CALC_W'(ceiling_reg);
    assign need_ext = CALC_W'(s2_item.need);
    assign sum      = lvl_ext + CALC_W'(s2_item.refill_units);

    always_comb
    begin
        case (s2_item.kind)
            REFILL_NONE: refilled = lvl_ext;
            REFILL_ADD:  refilled = (sum > ceil_ext) ? ceil_ext : sum;
            REFILL_FULL: refilled = ceil_ext;
            default:     refilled = lvl_ext;
        endcase
    end

    assign left = refilled - need_ext;
    assign ok   = s2_item.bypass || (refilled >= need_ext);

    always_comb
    begin
        if (s2_item.bypass)
            level_next = level_reg;
        else if (ok)
            level_next = left[TOKEN_WIDTH-1:0];
        else
            level_next = refilled[TOKEN_WIDTH-1:0];

        allowed_sum_next  = allowed_sum_reg;
        rejected_sum_next = rejected_sum_reg;
        if (ok)
            allowed_sum_next = allowed_sum_reg + TOTAL_W'(s2_item.bytes);
        else
            rejected_sum_next = rejected_sum_reg + TOTAL_W'(s2_item.bytes);

        s3_item_next.granted      = ok;
        s3_item_next.level        = LVL_W'(level_next);
        s3_item_next.allowed_sum  = allowed_sum_next;
        s3_item_next.rejected_sum = rejected_sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg     <= 1'b0;
            ceiling_reg      <= RESET_CEIL[TOKEN_WIDTH-1:0];
            level_reg        <= RESET_SAT[TOKEN_WIDTH-1:0];
            allowed_sum_reg  <= '0;
            rejected_sum_reg <= '0;
        end
        else
        begin
            ceiling_reg <= ceiling_next;
            if (move)
            begin
                s3_valid_reg     <= 1'b1;
                level_reg        <= level_next;
                allowed_sum_reg  <= allowed_sum_next;
                rejected_sum_reg <= rejected_sum_next;
            end
            else if (s3_ready)
            begin
                s3_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
            s3_item_reg <= s3_item_next;
    end

    assign s3_valid = s3_valid_reg;
    assign s3_item  = s3_item_reg;

`ifndef SYNTHESIS
    // bucket state only changes when an item passes through
    assert property (@(posedge clk) disable iff (!rst_n)
        !move |=> ($stable(level_reg) && $stable(allowed_sum_reg)
                   && $stable(rejected_sum_reg)))
        else $error("bucket state changed without an item");

    // unlimited items leave the level alone and are never rejected
    assert property (@(posedge clk) disable iff (!rst_n)
        (move && s2_item.bypass) |=> ($stable(level_reg) && $stable(rejected_sum_reg)))
        else $error("unlimited item touched the level or was rejected");

    // a full refill never leaves the level above the ceiling
    assert property (@(posedge clk) disable iff (!rst_n)
        (move && !s2_item.bypass && s2_item.kind == REFILL_FULL)
        |=> (level_reg <= $past(ceiling_reg)))
        else $error("level above ceiling after full refill");
`endif

endmodule

`default_nettype wire

// ----- rtl/tbbl_kb_div.sv -----
`default_nettype none

module tbbl_kb_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s3_valid,
    output logic                               s3_ready,
    input  wire tbbl_pkg::s3_item_t            s3_item,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               granted,
    output logic [tbbl_pkg::AVAIL_W-1:0]       available_kb,
    output logic [tbbl_pkg::TOTAL_W-1:0]       allowed_bytes_total,
    output logic [tbbl_pkg::TOTAL_W-1:0]       rejected_bytes_total
);
    import tbbl_pkg::*;

    logic                  move;
    logic [QUOT_X_W-1:0]   x;
    logic [QPROD_W-1:0]    qprod;
    logic                  out_valid_reg;
    logic                  granted_reg;
    logic [AVAIL_W-1:0]    available_reg;
    logic [TOTAL_W-1:0]    allowed_reg;
    logic [TOTAL_W-1:0]    rejected_reg;

    assign s3_ready = !out_valid_reg || out_ready;
    assign move     = s3_valid && s3_ready;

    // divide by 2^13, then by 125 through the reciprocal
    assign x     = s3_item.level[LVL_W-1:KB_SHIFT];
    assign qprod = QPROD_W'(x) * QPROD_W'(RECIP_125);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (move)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            granted_reg   <= s3_item.granted;
            available_reg <= qprod[RECIP_SHIFT+AVAIL_W-1:RECIP_SHIFT];
            allowed_reg   <= s3_item.allowed_sum;
            rejected_reg  <= s3_item.rejected_sum;
        end
    end

    assign out_valid            = out_valid_reg;
    assign granted              = granted_reg;
    assign available_kb         = available_reg;
    assign allowed_bytes_total  = allowed_reg;
    assign rejected_bytes_total = rejected_reg;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import tbbl_pkg::*;

    localparam int TOKEN_BITS = 42;
    localparam logic [63:0] TOKEN_CAP = (64'd1 << TOKEN_BITS) - 64'd1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    // index past the register list, the block must drop the write
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int IDLE_PCT = 29;

    // one transfer request item and the result it should produce
    typedef struct {
        logic [BYTE_W-1:0] bytes;
        logic [TIME_W-1:0] ms;
    } request_t;

    typedef struct {
        logic               ok;
        logic [AVAIL_W-1:0] avail_kb;
        logic [TOTAL_W-1:0] sent;
        logic [TOTAL_W-1:0] refused;
    } verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [BYTE_W-1:0]     byte_count = '0;
    logic [TIME_W-1:0]     now_ms = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  granted;
    logic [AVAIL_W-1:0]    available_kb;
    logic [TOTAL_W-1:0]    allowed_bytes_total;
    logic [TOTAL_W-1:0]    rejected_bytes_total;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    request_t request_q[$];   // requests waiting for the driver
    verdict_t verdict_q[$];   // predicted results, oldest first
    int       idle_pct = IDLE_PCT;
    int       fail_count = 0;
    logic [63:0] clock_ms = '0;   // running time base for random timestamps

    // bucket mirror: registers and state kept alongside the block
    logic [RATE_W-1:0] m_rate;
    logic [KB_W-1:0]   m_capacity;
    logic [KB_W-1:0]   m_burst;
    logic [63:0]       bucket_units;  // level in 1/1024000 KB
    logic [63:0]       stamp_ms;      // last accepted time, 0 means unset
    logic [63:0]       sent_bytes;
    logic [63:0]       refused_bytes;

    token_bucket_byte_limiter_top #(
        .TOKEN_WIDTH(TOKEN_BITS)
    ) i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .byte_count          (byte_count),
        .now_ms              (now_ms),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .granted             (granted),
        .available_kb        (available_kb),
        .allowed_bytes_total (allowed_bytes_total),
        .rejected_bytes_total(rejected_bytes_total),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // KB to token units, clipped at the token register width
    function automatic logic [63:0] units_of_kb(logic [63:0] kb);
        logic [63:0] u;
        u = kb * KB_UNITS;
        return (u > TOKEN_CAP) ? TOKEN_CAP : u;
    endfunction

    // refill, grant decision and totals for one request; updates the mirror
    function automatic verdict_t serve_request(request_t rq);
        verdict_t    v;
        logic [63:0] ceiling;
        logic [63:0] per_ms;
        logic [63:0] elapsed;
        logic [63:0] need;
        logic        ok;
        if (m_rate == '0)
        begin
            // limiting off: grant, no refill, time untouched
            ok = 1'b1;
        end
        else
        begin
            if (stamp_ms == '0)
            begin
                // first timestamp only arms the clock
                stamp_ms = rq.ms;
            end
            else if (rq.ms > stamp_ms)
            begin
                elapsed = rq.ms - stamp_ms;
                ceiling = units_of_kb(64'(m_capacity) + 64'(m_burst));
                per_ms  = 64'(m_rate) << UNIT_SHIFT;
                // a level above a lowered ceiling snaps down on any refill
                if (bucket_units >= ceiling)
                    bucket_units = ceiling;
                else if (elapsed > (ceiling - bucket_units) / per_ms)
                    bucket_units = ceiling;
                else
                    bucket_units = bucket_units + elapsed * per_ms;
                stamp_ms = rq.ms;
            end
            need = 64'(rq.bytes) * BYTE_UNITS;
            ok = (bucket_units >= need);
            if (ok)
                bucket_units = bucket_units - need;
        end
        if (ok)
            sent_bytes = sent_bytes + 64'(rq.bytes);
        else
            refused_bytes = refused_bytes + 64'(rq.bytes);
        v.ok       = ok;
        v.avail_kb = AVAIL_W'(bucket_units / KB_UNITS);
        v.sent     = sent_bytes;
        v.refused  = refused_bytes;
        return v;
    endfunction

    function automatic int field_differs(string name, logic [63:0] want, logic [63:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1;
    endfunction

    // byte counts spread from tiny to full width so both grants and rejects show up
    function automatic logic [BYTE_W-1:0] pick_bytes();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(0, 2048);
        if (r < 70)
            return $urandom_range(0, 1 << 17);
        if (r < 85)
            return $urandom_range(0, 1 << 24);
        if (r < 95)
            return $urandom;
        return r[0] ? '1 : '0;
    endfunction

    // mostly forward-moving time, with repeats, stale stamps, zeros and jumps;
    // wild mode also throws in fully random 64-bit stamps
    function automatic logic [TIME_W-1:0] pick_ms(bit wild);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (wild && r < 30)
            return {$urandom, $urandom};
        if (r < 60)
            clock_ms = clock_ms + $urandom_range(0, 20);
        else if (r < 75)
            clock_ms = clock_ms + $urandom_range(0, 5000);
        else if (r < 87)
            return clock_ms - $urandom_range(0, 30);
        else if (r < 92)
            return '0;
        else
            clock_ms = clock_ms + {$urandom_range(0, 3), $urandom};
        return clock_ms;
    endfunction

    task automatic send(logic [BYTE_W-1:0] bytes, logic [TIME_W-1:0] ms);
        request_t rq;
        rq.bytes = bytes;
        rq.ms    = ms;
        request_q.push_back(rq);
    endtask

    task automatic send_random(int count, bit wild);
        for (int k = 0; k < count; k++)
            send(pick_bytes(), pick_ms(wild));
    endtask

    // one register write per clock; the mirror follows at once since the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_RATE:     m_rate = val;
            REG_CAPACITY: m_capacity = val[KB_W-1:0];
            REG_BURST:    m_burst = val[KB_W-1:0];
            default:      ;
        endcase
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] rate, logic [CFG_DATA_W-1:0] cap,
                             logic [CFG_DATA_W-1:0] burst);
        write_reg(REG_RATE, rate);
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_BURST, burst);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // idle means nothing queued, nothing offered and nothing outstanding;
    // checked on the falling edge so the clocked blocks have settled
    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_q.size() != 0 || in_valid || verdict_q.size() != 0);
        // four-stage pipe, extra settling margin before the next phase
        repeat (8) @(negedge clk);
    endtask

    // request driver: offers the next queued item, holds it until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                verdict_q.push_back(serve_request(request_t'{byte_count, now_ms}));
            if (!in_valid || in_ready)
            begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    in_valid   <= 1'b1;
                    byte_count <= request_q[0].bytes;
                    now_ms     <= request_q[0].ms;
                    void'(request_q.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: random backpressure, each taken item checked against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : result_check
        verdict_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual granted %0b available_kb %0d",
                             $time, granted, available_kb);
                    fail_count++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    fail_count += field_differs("granted", want.ok, granted);
                    fail_count += field_differs("available_kb", want.avail_kb, available_kb);
                    fail_count += field_differs("allowed_bytes_total", want.sent,
                                                allowed_bytes_total);
                    fail_count += field_differs("rejected_bytes_total", want.refused,
                                                rejected_bytes_total);
                end
            end
            out_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // watchdog, far beyond any correct run
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        m_rate        = RESET_RATE_KB;
        m_capacity    = RESET_CAPACITY_KB;
        m_burst       = RESET_BURST_KB;
        bucket_units  = units_of_kb(64'(RESET_CAPACITY_KB));
        stamp_ms      = '0;
        sent_bytes    = '0;
        refused_bytes = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, rate zero: everything granted, time never stored
        send('0, '0);
        send('1, TIME_MAX);
        send(32'd5000, 64'd12);
        wait_drained();

        // 1 KB per ms, bucket 1024 KB full from reset
        configure(24'd1000, 24'd1024, 24'd0);
        send(32'd1024, '0);                    // zero time leaves the clock unset
        send('0, 64'd1000);                    // first stamp only recorded
        send(32'd1047553, 64'd1000);           // same time, one byte too many
        send(32'd1047552, 64'd999);            // older time, empties the bucket
        send(32'd1, 64'd1001);                 // one ms of refill
        send('0, 64'd1_000_000);               // long gap fills to the ceiling
        wait_drained();

        // ceiling cut to 24 KB under a full bucket, fastest rate
        configure('1, 24'd16, 24'd8);
        send('0, 64'd1_000_001);               // refill clamps the level down
        send(32'd24576, 64'd1_000_001);        // exactly the whole bucket
        send('0, 64'd1_000_002);               // one ms at top rate hits the ceiling
        wait_drained();

        // widest ceiling, slowest rate; capacity data carries bits past its width
        configure(24'd1, '1, 24'hFFFFF);
        write_reg(REG_SPARE, '1);
        @(posedge clk);
        cfg_write <= 1'b0;
        send('0, 64'd1_000_003);
        send(32'd24577, 64'd1_000_003);
        send('0, 64'd1_000_003 + (64'd1 << 40));
        send('1, 64'd5);
        send(32'h8000_0000, 64'd5);
        send(32'd2147481600, 64'd6);           // drains the largest ceiling exactly
        wait_drained();

        clock_ms = 64'd1_000_013 + (64'd1 << 40);

        configure(24'd1000, 24'd64, 24'd64);
        send_random(200, 1'b0);
        wait_drained();

        // long stretch with no idling on either side, extreme settings
        idle_pct = 0;
        configure('1, 24'hFFFFF, 24'hFFFFF);
        send_random(200, 1'b0);
        wait_drained();
        idle_pct = IDLE_PCT;

        // zero ceiling: only empty requests pass once a refill clamps the level
        configure(24'd1, 24'd0, 24'd0);
        send_random(200, 1'b0);
        wait_drained();

        configure(24'd0, 24'd77, 24'd3);
        send_random(200, 1'b0);
        wait_drained();

        // sender holds off mid-phase until every result is back
        configure(24'd250, 24'd4, 24'hFFFFF);
        send_random(100, 1'b0);
        wait_drained();
        send_random(100, 1'b0);
        wait_drained();

        // noise with arbitrary timestamps, then the latest possible time last
        configure(24'd777, 24'd300, 24'd3);
        send_random(200, 1'b1);
        send('0, TIME_MAX);
        send('1, TIME_MAX);
        wait_drained();

        if (fail_count == 0 && verdict_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
